@@ hw/rtl/tcvr_pkg.sv @@
`default_nettype none

package tcvr_pkg;

  localparam int PALETTE_ENTRIES  = 8;
  localparam int COLOUR_ROM_DEPTH = 128;

  localparam logic [8:0]  FRAME_LINES         = 9'd307;
  localparam logic [15:0] FIRST_TAG_RESET     = 16'd184;
  localparam logic [8:0]  FIRST_VISIBLE_RESET = 9'd19;
  localparam logic [9:0]  LINE_WIDTH_RESET    = 10'd640;
  localparam logic [7:0]  CURSOR_POS_RESET    = 8'd128;
  localparam logic [9:0]  BYTE_PIXELS         = 10'd8;

  typedef enum logic [1:0] {
    ACT_FRAME_START = 2'd0,
    ACT_LINE        = 2'd1,
    ACT_PIXEL       = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_FIRST_TAG_ADDRESS  = 2'd0,
    CFG_FIRST_VISIBLE_LINE = 2'd1,
    CFG_LINE_WIDTH_PIXELS  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_TAG   = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0] next_tag_address;
    logic        next_tag_long;
    logic [15:0] pixel_data_address;
    logic        line_visible;
  } tag_word_t;

  typedef struct packed {
    logic [7:0]  plane_zero;
    logic [7:0]  plane_one;
    logic [7:0]  plane_two;
    logic [1:0]  shift;
    logic [2:0]  luma;
    logic [31:0] palette_word;
    logic        cursor_hit;
    logic        cursor_graphical;
    logic [2:0]  cursor_bit;
    logic [3:0]  cursor_colour;
    logic [6:0]  count;
    logic        line_end;
  } pixel_job_t;

  typedef struct packed {
    kind_t      kind;
    tag_word_t  tag;
    pixel_job_t pix;
  } entry_t;

  localparam logic [31:0] COLOUR_ROM [COLOUR_ROM_DEPTH] = '{
    32'hFF000000, 32'hFF800000, 32'hFF008000, 32'hFF808000,
    32'hFF000080, 32'hFF800080, 32'hFF008080, 32'hFF808080,
    32'hFF000000, 32'hFFFF0000, 32'hFF00FF00, 32'hFFFFFF00,
    32'hFF0000FF, 32'hFFFF00FF, 32'hFF00FFFF, 32'hFFFFFFFF,
    32'hFF000000, 32'hFF600000, 32'hFF008000, 32'hFF608000,
    32'hFF000080, 32'hFF600080, 32'hFF008080, 32'hFF608080,
    32'hFF000000, 32'hFFDF0000, 32'hFF00FF00, 32'hFFDFFF00,
    32'hFF0000FF, 32'hFFDF00FF, 32'hFF00FFFF, 32'hFFDFFFFF,
    32'hFF000000, 32'hFF800000, 32'hFF006000, 32'hFF806000,
    32'hFF000080, 32'hFF800080, 32'hFF006080, 32'hFF806080,
    32'hFF000000, 32'hFFFF0000, 32'hFF00DF00, 32'hFFFFDF00,
    32'hFF0000FF, 32'hFFFF00FF, 32'hFF00DFFF, 32'hFFFFDFFF,
    32'hFF000000, 32'hFF600000, 32'hFF006000, 32'hFF606000,
    32'hFF000080, 32'hFF600080, 32'hFF006080, 32'hFF606080,
    32'hFF000000, 32'hFFDF0000, 32'hFF00DF00, 32'hFFDFDF00,
    32'hFF0000FF, 32'hFFDF00FF, 32'hFF00DFFF, 32'hFFDFDFFF,
    32'hFF000000, 32'hFF800000, 32'hFF008000, 32'hFF808000,
    32'hFF000060, 32'hFF800060, 32'hFF008060, 32'hFF808060,
    32'hFF000000, 32'hFFFF0000, 32'hFF00FF00, 32'hFFFFFF00,
    32'hFF0000DF, 32'hFFFF00DF, 32'hFF00FFDF, 32'hFFFFFFDF,
    32'hFF000000, 32'hFF600000, 32'hFF008000, 32'hFF608000,
    32'hFF000060, 32'hFF600060, 32'hFF008060, 32'hFF608060,
    32'hFF000000, 32'hFFDF0000, 32'hFF00FF00, 32'hFFDFFF00,
    32'hFF0000DF, 32'hFFDF00DF, 32'hFF00FFDF, 32'hFFDFFFDF,
    32'hFF000000, 32'hFF800000, 32'hFF006000, 32'hFF806000,
    32'hFF000060, 32'hFF800060, 32'hFF006060, 32'hFF806060,
    32'hFF000000, 32'hFFFF0000, 32'hFF00DF00, 32'hFFFFDF00,
    32'hFF0000DF, 32'hFFFF00DF, 32'hFF00DFDF, 32'hFFFFDFDF,
    32'hFF000000, 32'hFF600000, 32'hFF006000, 32'hFF606000,
    32'hFF000060, 32'hFF600060, 32'hFF006060, 32'hFF606060,
    32'hFF000000, 32'hFFDF0000, 32'hFF00DF00, 32'hFFDFDF00,
    32'hFF0000DF, 32'hFFDF00DF, 32'hFF00DFDF, 32'hFFDFDFDF
  };

endpackage

`default_nettype wire

@@ hw/rtl/tcvr_front.sv @@
`default_nettype none

module tcvr_front import tcvr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        accept,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] tag_word_one,
  input  wire logic [15:0] tag_word_two,
  input  wire logic [15:0] plane_address_word,
  input  wire logic [15:0] next_link_word,
  input  wire logic [7:0]  plane_zero_byte,
  input  wire logic [7:0]  plane_one_byte,
  input  wire logic [7:0]  plane_two_byte,
  output logic             push,
  output entry_t           push_entry
);

  logic [15:0] first_tag_address;
  logic [8:0]  first_visible_line;
  logic [9:0]  line_width_pixels;

  logic        long_tag_pending;
  logic        palette_tag_pending;
  logic [1:0]  shift;
  logic [2:0]  luma;
  logic [31:0] palette_word;
  logic [3:0]  cursor_colour;
  logic        cursor_graphical;
  logic [7:0]  cursor_byte_pos;
  logic [2:0]  cursor_bit;
  logic        cursor_visible;
  logic [8:0]  line_count;
  logic [7:0]  byte_position;
  logic [9:0]  pixels_left;
  logic        drawing;

  logic        line_vis;
  logic        next_long;
  logic [15:0] next_addr;
  logic [1:0]  new_shift;
  logic [7:0]  cursor_pos_shifted;
  logic [9:0]  group_size;
  logic [9:0]  group_count;
  logic        group_ends_line;

  always_comb begin
    line_vis           = (line_count >= first_visible_line) && (line_count < FRAME_LINES);
    next_long          = next_link_word[1];
    next_addr          = next_long ? {next_link_word[15:3], 3'b000}
                                   : {next_link_word[15:2], 2'b00};
    new_shift          = tag_word_two[5:4];
    cursor_pos_shifted = tag_word_one[15:8] >> new_shift;
    group_size         = BYTE_PIXELS << shift;
    group_ends_line    = pixels_left <= group_size;
    group_count        = group_ends_line ? pixels_left : group_size;
  end

  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    if (accept) begin
      unique case (action)
        ACT_FRAME_START: begin
          push                            = 1'b1;
          push_entry.kind                 = KIND_TAG;
          push_entry.tag.next_tag_address = first_tag_address;
        end
        ACT_LINE: begin
          push                              = 1'b1;
          push_entry.kind                   = KIND_TAG;
          push_entry.tag.next_tag_address   = next_addr;
          push_entry.tag.next_tag_long      = next_long;
          push_entry.tag.pixel_data_address = plane_address_word;
          push_entry.tag.line_visible       = line_vis;
        end
        ACT_PIXEL: begin
          push                            = drawing;
          push_entry.kind                 = KIND_PIXEL;
          push_entry.pix.plane_zero       = plane_zero_byte;
          push_entry.pix.plane_one        = plane_one_byte;
          push_entry.pix.plane_two        = plane_two_byte;
          push_entry.pix.shift            = shift;
          push_entry.pix.luma             = luma;
          push_entry.pix.palette_word     = palette_word;
          push_entry.pix.cursor_hit       = cursor_visible && (byte_position == cursor_byte_pos);
          push_entry.pix.cursor_graphical = cursor_graphical;
          push_entry.pix.cursor_bit       = cursor_bit;
          push_entry.pix.cursor_colour    = cursor_colour;
          push_entry.pix.count            = group_count[6:0];
          push_entry.pix.line_end         = group_ends_line;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_tag_address  <= FIRST_TAG_RESET;
      first_visible_line <= FIRST_VISIBLE_RESET;
      line_width_pixels  <= LINE_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIRST_TAG_ADDRESS:  first_tag_address  <= cfg_data;
        CFG_FIRST_VISIBLE_LINE: first_visible_line <= cfg_data[8:0];
        CFG_LINE_WIDTH_PIXELS:  line_width_pixels  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && action == ACT_FRAME_START)) begin
      long_tag_pending    <= 1'b0;
      palette_tag_pending <= 1'b0;
      shift               <= 2'd0;
      luma                <= 3'd0;
      palette_word        <= 32'd0;
      cursor_colour       <= 4'd0;
      cursor_graphical    <= 1'b0;
      cursor_byte_pos     <= CURSOR_POS_RESET;
      cursor_bit          <= 3'd0;
      cursor_visible      <= 1'b0;
      line_count          <= 9'd0;
      byte_position       <= 8'd0;
      pixels_left         <= rst ? LINE_WIDTH_RESET : line_width_pixels;
      drawing             <= 1'b0;
    end else if (accept && action == ACT_LINE) begin
      if (long_tag_pending) begin
        if (palette_tag_pending) begin
          palette_word <= {tag_word_two, tag_word_one};
        end else begin
          shift            <= new_shift;
          luma             <= 3'd7 - tag_word_two[2:0];
          cursor_colour    <= tag_word_one[3:0];
          cursor_graphical <= tag_word_one[4];
          cursor_bit       <= tag_word_one[7:5];
          cursor_byte_pos  <= {1'b0, cursor_pos_shifted[6:0]};
        end
      end
      long_tag_pending <= next_long;
      if (next_long) begin
        palette_tag_pending <= next_link_word[2];
      end
      cursor_visible <= cursor_visible ^ next_link_word[0];
      if (line_count < FRAME_LINES) begin
        line_count <= line_count + 9'd1;
      end
      byte_position <= 8'd0;
      pixels_left   <= line_vis ? line_width_pixels : 10'd0;
      drawing       <= line_vis && (line_width_pixels != 10'd0);
    end else if (accept && action == ACT_PIXEL && drawing) begin
      pixels_left   <= pixels_left - group_count;
      drawing       <= !group_ends_line;
      byte_position <= byte_position + 8'd1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcvr_queue.sv @@
`default_nettype none

module tcvr_queue import tcvr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  entry_t    push_entry,
  output logic      full,
  input  wire logic pop,
  output entry_t    head,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [CW-1:0]   fill;

  assign full  = fill == CW'(DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcvr_back.sv @@
`default_nettype none

module tcvr_back import tcvr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  entry_t           head,
  input  wire logic        empty,
  output logic             pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             result_kind,
  output logic [15:0]      next_tag_address,
  output logic             next_tag_long,
  output logic [15:0]      pixel_data_address,
  output logic             line_visible,
  output logic [31:0]      pixel_rgba,
  output logic             group_last,
  output logic             line_end
);

  pixel_job_t  job;
  logic        active;
  logic [5:0]  pixel_index;

  logic        advance;
  logic        last_pixel;
  logic [5:0]  bit_wide;
  logic [2:0]  bit_sel;
  logic [2:0]  plane_value;
  logic [3:0]  nibble;
  logic [6:0]  rom_index;
  logic        cursor_here;
  logic [31:0] colour;

  always_comb begin
    advance     = !result_valid || !result_stall;
    last_pixel  = active && (({1'b0, pixel_index} + 7'd1) == job.count);
    pop         = advance && !empty &&
                  (!active || (last_pixel && head.kind == KIND_PIXEL));
    bit_wide    = pixel_index >> job.shift;
    bit_sel     = bit_wide[2:0];
    plane_value = {job.plane_two[bit_sel], job.plane_one[bit_sel], job.plane_zero[bit_sel]};
    nibble      = job.palette_word[{plane_value, 2'b00} +: 4];
    cursor_here = job.cursor_hit && (!job.cursor_graphical || bit_sel == job.cursor_bit);
    rom_index   = cursor_here ? {3'b000, job.cursor_colour} : {job.luma, nibble};
    colour      = COLOUR_ROM[rom_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      active       <= 1'b0;
    end else if (advance) begin
      if (active) begin
        result_valid       <= 1'b1;
        result_kind        <= KIND_PIXEL;
        next_tag_address   <= 16'd0;
        next_tag_long      <= 1'b0;
        pixel_data_address <= 16'd0;
        line_visible       <= 1'b0;
        pixel_rgba         <= colour;
        group_last         <= last_pixel;
        line_end           <= last_pixel && job.line_end;
        pixel_index        <= pixel_index + 6'd1;
        if (last_pixel) begin
          active <= 1'b0;
        end
      end else if (!empty && head.kind == KIND_TAG) begin
        result_valid       <= 1'b1;
        result_kind        <= KIND_TAG;
        next_tag_address   <= head.tag.next_tag_address;
        next_tag_long      <= head.tag.next_tag_long;
        pixel_data_address <= head.tag.pixel_data_address;
        line_visible       <= head.tag.line_visible;
        pixel_rgba         <= 32'd0;
        group_last         <= 1'b0;
        line_end           <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
      if (pop && head.kind == KIND_PIXEL) begin
        active      <= 1'b1;
        job         <= head.pix;
        pixel_index <= 6'd0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tag_chain_video_renderer_unit.sv @@
// Path: a tag word passes through the queue and the output register; the first pixel of a
// plane-byte item passes through the queue, the job register and the output register.
// Throughput: one result word per cycle while result_stall is low; a plane-byte item gives
// 8 << shift pixels (fewer at line end), plus an empty load step after idle or a tag word.
// Reset is synchronous: configuration returns to its defaults, the frame state is cleared
// and the queue and output register are emptied.
`default_nettype none

module tag_chain_video_renderer_unit import tcvr_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] tag_word_one,
  input  wire logic [15:0] tag_word_two,
  input  wire logic [15:0] plane_address_word,
  input  wire logic [15:0] next_link_word,
  input  wire logic [7:0]  plane_zero_byte,
  input  wire logic [7:0]  plane_one_byte,
  input  wire logic [7:0]  plane_two_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             result_kind,
  output logic [15:0]      next_tag_address,
  output logic             next_tag_long,
  output logic [15:0]      pixel_data_address,
  output logic             line_visible,
  output logic [31:0]      pixel_rgba,
  output logic             group_last,
  output logic             line_end
);

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;
  logic   accept;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  tcvr_front u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .accept             (accept),
    .action             (action),
    .tag_word_one       (tag_word_one),
    .tag_word_two       (tag_word_two),
    .plane_address_word (plane_address_word),
    .next_link_word     (next_link_word),
    .plane_zero_byte    (plane_zero_byte),
    .plane_one_byte     (plane_one_byte),
    .plane_two_byte     (plane_two_byte),
    .push               (q_push),
    .push_entry         (q_entry)
  );

  tcvr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  tcvr_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (q_head),
    .empty              (q_empty),
    .pop                (q_pop),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .result_kind        (result_kind),
    .next_tag_address   (next_tag_address),
    .next_tag_long      (next_tag_long),
    .pixel_data_address (pixel_data_address),
    .line_visible       (line_visible),
    .pixel_rgba         (pixel_rgba),
    .group_last         (group_last),
    .line_end           (line_end)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_pixel_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == KIND_PIXEL) |-> (q_head.pix.count != 7'd0))
    else $error("pixel job with no pixels");
`endif

endmodule

`default_nettype wire
